>>> hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/pwmpd_pkg.sv
// types and constants of the pwm period and duty calculator
`timescale 1ns / 1ps
`default_nettype none
package pwmpd_pkg;

  localparam int unsigned DIV_STAGES     = 32;
  localparam int unsigned FREQ_W         = 32;
  localparam int unsigned DUTY_W         = 16;
  localparam int unsigned CNT_W          = 16;
  localparam int unsigned CODE_W         = 3;
  localparam int unsigned PRESCALE_STEPS = 8;
  localparam int unsigned LIMIT_W        = FREQ_W + PRESCALE_STEPS;

  localparam logic [CNT_W-1:0]  MAX_PERIOD   = 16'hFFFF;
  localparam logic [FREQ_W-1:0] TICK_LIMIT   = 32'd65535;
  localparam logic [FREQ_W-1:0] CLOCK_RESET  = 32'd48000000;
  localparam logic [2*CNT_W-1:0] ROUND_HALF  = 32'h0000_8000;

  // one item in flight through the divider row
  typedef struct packed {
    logic [FREQ_W-1:0] rem;
    logic [FREQ_W-1:0] dvd;
    logic [FREQ_W-1:0] quo;
    logic [FREQ_W-1:0] div;
    logic [DUTY_W-1:0] duty;
    logic              zero;
  } div_item_t;

  // one finished result
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  period;
    logic [CNT_W-1:0]  compare;
    logic              status;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/pwm_period_duty_calculator.sv
// top level of the pwm period and duty calculator
//
//  channel  | dir | signals                           | payload
//  ---------+-----+-----------------------------------+-------------------------------
//  request  | in  | s_tvalid s_tready s_tdata[47:0]   | frequency_hz, duty_fraction
//  result   | out | m_tvalid m_tready m_tdata m_tuser | code, period, compare / status
//  config   | in  | cfg_wr_en cfg_wr_data[31:0]       | clock_hz
//
// one transaction accepted per cycle while the pipe is not backed up; 32 divider cells
// (one quotient bit each) plus the prescale/clamp stage and the multiply stage
// every stage has its own valid bit and stalls only when the stage below is full
// and not draining, so bubbles close up while the output waits
// rst is synchronous; it clears the valid bits and restores clock_hz to 48 MHz
`timescale 1ns / 1ps
`default_nettype none
module pwm_period_duty_calculator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // frequency_hz[31:0], duty_fraction[47:32]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // prescale_code[2:0], period_count[18:3],
                                      // compare_count[34:19], zero pad[39:35]
  output logic             m_tuser,   // status
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  localparam int unsigned N = pwmpd_pkg::DIV_STAGES;

  logic [pwmpd_pkg::FREQ_W-1:0] clock_hz;

  // chain of cells: index 0 is the input side, index N feeds the finish stages
  logic                  chain_valid [N+1];
  logic                  chain_ready [N+1];
  pwmpd_pkg::div_item_t  chain_item  [N+1];
  pwmpd_pkg::result_t    result;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= pwmpd_pkg::CLOCK_RESET;
    end else if (cfg_wr_en) begin
      clock_hz <= cfg_wr_data;
    end
  end

  // load the dividend from clock_hz, divisor from the request
  always_comb begin
    chain_valid[0]     = s_tvalid;
    chain_item[0].rem  = '0;
    chain_item[0].dvd  = clock_hz;
    chain_item[0].quo  = '0;
    chain_item[0].div  = s_tdata[31:0];
    chain_item[0].duty = s_tdata[47:32];
    chain_item[0].zero = s_tdata[31:0] == '0;
  end
  assign s_tready = chain_ready[0];

  for (genvar k = 0; k < N; k++) begin : g_cell
    pwmpd_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[k]),
      .up_item  (chain_item[k]),
      .up_ready (chain_ready[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_item  (chain_item[k+1]),
      .dn_ready (chain_ready[k+1])
    );
  end

  // quotient clock_hz / frequency_hz done; pick prescaler, clamp, scale duty
  pwmpd_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (chain_valid[N]),
    .up_item   (chain_item[N]),
    .up_ready  (chain_ready[N]),
    .dn_valid  (m_tvalid),
    .dn_result (result),
    .dn_ready  (m_tready)
  );

  assign m_tdata = {5'b0, result.compare, result.period, result.code};
  assign m_tuser = result.status;

endmodule
`default_nettype wire

>>> hdl/pwmpd_div_cell.sv
// one restoring-division cell: produces one quotient bit per item
`timescale 1ns / 1ps
`default_nettype none
module pwmpd_div_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 up_valid,
  input  pwmpd_pkg::div_item_t      up_item,
  output logic                      up_ready,
  output logic                      dn_valid,
  output pwmpd_pkg::div_item_t      dn_item,
  input  wire logic                 dn_ready
);

  logic [pwmpd_pkg::FREQ_W:0] trial;
  logic                       ge;
  pwmpd_pkg::div_item_t       item_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    trial     = {up_item.rem, up_item.dvd[pwmpd_pkg::FREQ_W-1]};
    ge        = trial >= {1'b0, up_item.div};
    item_next = up_item;
    item_next.rem = ge ? pwmpd_pkg::FREQ_W'(trial - {1'b0, up_item.div})
                       : trial[pwmpd_pkg::FREQ_W-1:0];
    item_next.dvd = {up_item.dvd[pwmpd_pkg::FREQ_W-2:0], 1'b0};
    item_next.quo = {up_item.quo[pwmpd_pkg::FREQ_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= item_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/pwmpd_finish.sv
// prescale choice, period clamp and compare multiply, two stages
`timescale 1ns / 1ps
`default_nettype none
module pwmpd_finish (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 up_valid,
  input  pwmpd_pkg::div_item_t      up_item,
  output logic                      up_ready,
  output logic                      dn_valid,
  output pwmpd_pkg::result_t        dn_result,
  input  wire logic                 dn_ready
);

  // stage one registers
  logic                            s1_valid;
  logic [pwmpd_pkg::CODE_W-1:0]    s1_code;
  logic [pwmpd_pkg::CNT_W-1:0]     s1_period;
  logic [pwmpd_pkg::DUTY_W-1:0]    s1_duty;
  logic                            s1_zero;
  logic                            s1_ready;

  logic [pwmpd_pkg::CODE_W-1:0]    code_next;
  logic [pwmpd_pkg::FREQ_W-1:0]    shifted;
  logic [pwmpd_pkg::CNT_W-1:0]     period_next;
  logic [2*pwmpd_pkg::CNT_W-1:0]   product;
  pwmpd_pkg::result_t              result_next;

  assign up_ready = !s1_valid || s1_ready;
  assign s1_ready = !dn_valid || dn_ready;

  // smallest code whose scaled limit covers the quotient
  always_comb begin
    code_next = pwmpd_pkg::CODE_W'(pwmpd_pkg::PRESCALE_STEPS - 1);
    for (int c = pwmpd_pkg::PRESCALE_STEPS - 2; c >= 0; c--) begin
      if ({{pwmpd_pkg::PRESCALE_STEPS{1'b0}}, up_item.quo} <=
          ({{pwmpd_pkg::PRESCALE_STEPS{1'b0}}, pwmpd_pkg::TICK_LIMIT} << c)) begin
        code_next = pwmpd_pkg::CODE_W'(c);
      end
    end
    shifted = up_item.quo >> code_next;
    if (shifted == '0) begin
      period_next = pwmpd_pkg::CNT_W'(1);
    end else if (shifted > {{(pwmpd_pkg::FREQ_W-pwmpd_pkg::CNT_W){1'b0}},
                            pwmpd_pkg::MAX_PERIOD}) begin
      period_next = pwmpd_pkg::MAX_PERIOD;
    end else begin
      period_next = shifted[pwmpd_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    product = s1_duty * s1_period + pwmpd_pkg::ROUND_HALF;
    if (s1_zero) begin
      result_next = '0;
      result_next.status = 1'b1;
    end else begin
      result_next.code    = s1_code;
      result_next.period  = s1_period;
      result_next.compare = product[2*pwmpd_pkg::CNT_W-1:pwmpd_pkg::CNT_W];
      result_next.status  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (up_ready) begin
        s1_valid <= up_valid;
      end
      if (s1_ready) begin
        dn_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s1_code   <= code_next;
      s1_period <= period_next;
      s1_duty   <= up_item.duty;
      s1_zero   <= up_item.zero;
    end
    if (s1_ready && s1_valid) begin
      dn_result <= result_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/pwmpd_checker.sv
// port-level checker for the pwm period and duty calculator, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pwmpd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tuser
);

  // a waiting result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  // error results carry all-zero settings
  `ASSERT_IMPLY(a_err_zero, clk, rst, m_tvalid && m_tuser, m_tdata == 40'd0)
  // good results never have a zero period
  `ASSERT_IMPLY(a_period_nz, clk, rst, m_tvalid && !m_tuser, m_tdata[18:3] != 16'd0)
  // compare never passes the period
  `ASSERT_IMPLY(a_cmp_le, clk, rst, m_tvalid && !m_tuser, m_tdata[34:19] <= m_tdata[18:3])

endmodule

bind pwm_period_duty_calculator pwmpd_checker u_pwmpd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

>>> dv/pwm_period_duty_calculator_tb.sv
// testbench for the pwm period and duty calculator
`timescale 1ns / 1ps
module pwm_period_duty_calculator_tb;

  localparam int unsigned LATENCY     = 35;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned LONG_HOLD   = 400;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  // pending requests, expected timer settings, clock held by the predictor
  logic [47:0]          pending_req[$];
  pwmpd_pkg::result_t   expected_settings[$];
  logic [31:0]          timer_clock_hz;
  int unsigned          send_idle_pct;
  int unsigned          recv_stall_pct;
  logic                 recv_block;
  int unsigned          mismatches;
  int unsigned          requests_sent;
  int unsigned          results_checked;
  int unsigned          zero_freq_seen;

  pwm_period_duty_calculator u_top (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // prescale code, clamped period and rounded compare for one request
  function automatic pwmpd_pkg::result_t calc_timer_settings(logic [31:0] freq,
                                                             logic [15:0] duty,
                                                             logic [31:0] clock_hz);
    pwmpd_pkg::result_t r;
    logic [63:0] ideal_div;
    logic [63:0] period;
    logic [63:0] cmp;
    int unsigned c;
    r = '0;
    if (freq == 0) begin
      r.status = 1'b1;
      return r;
    end
    ideal_div = (64'(clock_hz) / 64'(freq) + 64'd65534) / 64'd65535;
    c = 0;
    while (c < pwmpd_pkg::PRESCALE_STEPS - 1 && ideal_div > (64'd1 << c)) c++;
    period = (64'(clock_hz) >> c) / 64'(freq);
    if (period < 1) period = 1;
    else if (period > 64'd65535) period = 64'd65535;
    cmp = (64'(duty) * period + 64'h8000) >> 16;
    r.code    = pwmpd_pkg::CODE_W'(c);
    r.period  = period[15:0];
    r.compare = cmp[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("MISMATCH %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // random frequencies, some aimed at the prescale boundaries for the current clock
  function automatic logic [31:0] pick_frequency();
    logic [31:0] base;
    case ($urandom_range(4))
      0: return $urandom();
      1: return $urandom_range(1, 1000);
      2: begin
        base = timer_clock_hz / (32'd65535 << $urandom_range(7));
        return base + $urandom_range(2) - 1;
      end
      3: return $urandom_range(1, 200000);
      default: return ($urandom_range(30) == 0) ? 32'd0 : $urandom_range(1, 65536);
    endcase
  endfunction

  // driver: predicts at each accepted transaction, then offers the next request
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_settings.push_back(
          calc_timer_settings(s_tdata[31:0], s_tdata[47:32], timer_clock_hz));
        requests_sent++;
        if (s_tdata[31:0] == 0) zero_freq_seen++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_req.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata  <= pending_req.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result against the oldest expectation
  always @(posedge clk) begin
    pwmpd_pkg::result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_settings.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, 0);
        end else begin
          want = expected_settings.pop_front();
          results_checked++;
          if (m_tdata[2:0] !== want.code)
            report_mismatch("prescale_code", m_tdata[2:0], want.code);
          if (m_tdata[18:3] !== want.period)
            report_mismatch("period_count", m_tdata[18:3], want.period);
          if (m_tdata[34:19] !== want.compare)
            report_mismatch("compare_count", m_tdata[34:19], want.compare);
          if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
        end
      end
      m_tready <= !recv_block && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_req.size() > 0 || s_tvalid || expected_settings.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_clock(logic [31:0] value);
    @(posedge clk);
    cfg_wr_en      <= 1'b1;
    cfg_wr_data    <= value;
    timer_clock_hz  = value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
  endtask

  initial begin
    logic [31:0] clocks[7];
    int unsigned send_modes[4];
    int unsigned recv_modes[4];
    clk = 0; rst = 1; s_tvalid = 0; s_tdata = '0; m_tready = 0;
    cfg_wr_en = 0; cfg_wr_data = '0; recv_block = 0;
    send_idle_pct = 0; recv_stall_pct = 0; timer_clock_hz = 32'd48000000;
    mismatches = 0; requests_sent = 0; results_checked = 0; zero_freq_seen = 0;
    clocks = '{32'd48000000, 32'd1, 32'hFFFF_FFFF, 32'd1000000, 32'd0,
               32'd0, 32'd48000000};
    clocks[4] = $urandom();
    send_modes = '{0, 53, 0, 28};
    recv_modes = '{0, 0, 53, 28};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: zero and extreme frequencies, duty extremes, each prescale step
    pending_req.push_back({16'h8000, 32'd0});
    pending_req.push_back({16'hFFFF, 32'd0});
    pending_req.push_back({16'h0000, 32'd1});
    pending_req.push_back({16'hFFFF, 32'd1});
    pending_req.push_back({16'hFFFF, 32'hFFFF_FFFF});
    pending_req.push_back({16'h8000, 32'hFFFF_FFFF});
    pending_req.push_back({16'h0001, 32'd48000000});
    pending_req.push_back({16'h8000, 32'd732});
    pending_req.push_back({16'h8000, 32'd733});
    for (int k = 0; k < 8; k++) begin
      pending_req.push_back({16'hFFFF, 32'd48000000 / (32'd65535 << k)});
      pending_req.push_back({16'h7FFF, 32'd48000000 / (32'd65535 << k) + 1});
    end

    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        wait_drained();
        repeat (LATENCY + 5) @(posedge clk);
        write_clock(clocks[p]);
      end
      send_idle_pct  = send_modes[p % 4];
      recv_stall_pct = recv_modes[p % 4];
      for (int i = 0; i < PHASE_ITEMS; i++)
        pending_req.push_back({16'($urandom()), pick_frequency()});
      // receiver holds off while the sender keeps offering, so the pipe backs up
      if (p == 1) begin
        @(posedge clk);
        recv_block <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        recv_block <= 1'b0;
      end
    end
    wait_drained();
    repeat (LATENCY + 5) @(posedge clk);
    $display("covered %0d requests (%0d zero frequency) over 7 clock settings incl. 0, 1, max",
             requests_sent, zero_freq_seen);
    $display("checked %0d results under four idle/stall mixes and a long output hold",
             results_checked);
    if (mismatches == 0) begin
      $display("pwm_period_duty_calculator_tb: done, clean");
    end else begin
      $display("pwm_period_duty_calculator_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout waiting for results");
    $display("pwm_period_duty_calculator_tb: done, errors");
    $finish;
  end

endmodule
